/* rtl/i2cme_pkg.sv */
// ----------------------------------------------------------------------------
// i2cme_pkg
// Shared types and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cme_pkg;

    // Command codes as they arrive in the mode field
    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_STOP    = 3'd1,
        OP_WRITE   = 3'd2,
        OP_WAITACK = 3'd3,
        OP_READ    = 3'd4,
        OP_ACK     = 3'd5,
        OP_NACK    = 3'd6,
        OP_NOP     = 3'd7
    } op_t;

    // One decoded tick, as queued between front and back
    typedef struct packed {
        logic       go;          // a real command is offered this tick
        op_t        op;
        logic [7:0] tx_byte;
        logic       sda_sample;
    } cmd_t;

    // One result; last field in the lowest bits
    typedef struct packed {
        logic       ack_failed;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       scl_drive;
    } res_t;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 16;
    localparam int RES_W       = $bits(res_t);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 2'd1;

    localparam logic [15:0] PHASE_TICKS_RESET    = 16'd30;
    localparam logic [7:0]  ACK_POLL_LIMIT_RESET = 8'd200;

endpackage

/* rtl/i2cme_front.sv */
// ----------------------------------------------------------------------------
// i2cme_front
// Unpacks an input transfer and classifies it into a queued command tick.
// ----------------------------------------------------------------------------
module i2cme_front (
    input  logic [i2cme_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic [i2cme_pkg::IN_TUSER_W-1:0] s_axis_tuser,
    output i2cme_pkg::cmd_t                  cmd
);
    import i2cme_pkg::*;

    op_t mode;

    always_comb begin
        mode           = op_t'(s_axis_tuser[3:1]);
        cmd.op         = mode;
        cmd.go         = s_axis_tuser[0] && (mode != OP_NOP);
        cmd.tx_byte    = s_axis_tdata[7:0];
        cmd.sda_sample = s_axis_tdata[8];
    end

endmodule

/* rtl/i2cme_queue.sv */
// ----------------------------------------------------------------------------
// i2cme_queue
// Small FIFO of decoded command ticks between the front and the sequencer.
// ----------------------------------------------------------------------------
module i2cme_queue #(
    parameter int DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  i2cme_pkg::cmd_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output i2cme_pkg::cmd_t pop_data
);
    import i2cme_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/i2cme_back.sv */
// ----------------------------------------------------------------------------
// i2cme_back
// Bus phase sequencer: steps once per queued tick, holds the config
// registers and the output register of the result channel.
// ----------------------------------------------------------------------------
module i2cme_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  i2cme_pkg::cmd_t                     q_data,
    output logic                                q_pop,
    input  logic                                cfg_valid,
    input  logic [i2cme_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [i2cme_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [i2cme_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import i2cme_pkg::*;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_START,
        SQ_STOP,
        SQ_WRITE,
        SQ_WAITACK,
        SQ_READ,
        SQ_ACKNACK
    } seq_t;

    seq_t        state_reg, state_next;
    logic [1:0]  step_reg, step_next;
    logic [15:0] phase_reg, phase_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  poll_reg, poll_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        fail_reg, fail_next;
    logic [7:0]  rx_reg, rx_next;
    logic        done;

    logic [15:0] phase_ticks_reg;
    logic [7:0]  poll_limit_reg;
    logic [15:0] hold_ticks;
    logic [15:0] phase_dec;
    logic [3:0]  bit_inc;
    logic [7:0]  shift_in;

    logic        m_valid_reg;
    res_t        m_res_reg;
    res_t        res;

    assign q_pop         = q_valid && (!m_valid_reg || m_axis_tready);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, m_res_reg};

    assign hold_ticks = (phase_ticks_reg == '0) ? 16'd1 : phase_ticks_reg;
    assign phase_dec  = (phase_reg != '0) ? phase_reg - 16'd1 : 16'd0;
    assign bit_inc    = bit_reg + 4'd1;
    assign shift_in   = shift_reg | {7'd0, q_data.sda_sample};

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        poll_next  = poll_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        fail_next  = fail_reg;
        rx_next    = rx_reg;
        done       = 1'b0;

        if (state_reg == SQ_IDLE) begin
            if (q_data.go) begin
                step_next  = 2'd0;
                phase_next = hold_ticks;
                unique case (q_data.op)
                    OP_START: begin
                        state_next = SQ_START;
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                    end
                    OP_STOP: begin
                        state_next = SQ_STOP;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                    end
                    OP_WRITE: begin
                        state_next = SQ_WRITE;
                        bit_next   = 4'd0;
                        scl_next   = 1'b0;
                        sda_next   = q_data.tx_byte[7];
                        shift_next = {q_data.tx_byte[6:0], 1'b0};
                    end
                    OP_WAITACK: begin
                        state_next = SQ_WAITACK;
                        fail_next  = 1'b0;
                        poll_next  = 8'd0;
                        sda_next   = 1'b1;
                    end
                    OP_READ: begin
                        state_next = SQ_READ;
                        sda_next   = 1'b1;
                        scl_next   = 1'b0;
                        shift_next = 8'd0;
                        bit_next   = 4'd0;
                    end
                    OP_ACK: begin
                        state_next = SQ_ACKNACK;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                    end
                    OP_NACK: begin
                        state_next = SQ_ACKNACK;
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                    end
                    OP_NOP: begin
                        state_next = SQ_IDLE;
                    end
                endcase
            end
        end else if (state_reg == SQ_WAITACK && step_reg == 2'd2) begin
            // poll SDA once per tick until low or the limit is passed
            if (!q_data.sda_sample) begin
                scl_next   = 1'b0;
                state_next = SQ_IDLE;
                step_next  = 2'd0;
                phase_next = 16'd0;
                done       = 1'b1;
            end else if (poll_reg >= poll_limit_reg) begin
                fail_next  = 1'b1;
                state_next = SQ_STOP;
                step_next  = 2'd0;
                scl_next   = 1'b0;
                sda_next   = 1'b0;
                phase_next = hold_ticks;
            end else begin
                poll_next = poll_reg + 8'd1;
            end
        end else begin
            phase_next = phase_dec;
            if (phase_dec == '0) begin
                unique case (state_reg)
                    SQ_START: begin
                        if (step_reg == 2'd0) begin
                            step_next  = 2'd1;
                            sda_next   = 1'b0;
                            phase_next = hold_ticks;
                        end else begin
                            scl_next   = 1'b0;
                            state_next = SQ_IDLE;
                            step_next  = 2'd0;
                            done       = 1'b1;
                        end
                    end
                    SQ_STOP: begin
                        if (step_reg == 2'd0) begin
                            step_next  = 2'd1;
                            scl_next   = 1'b1;
                            phase_next = hold_ticks;
                        end else if (step_reg == 2'd1) begin
                            step_next  = 2'd2;
                            sda_next   = 1'b1;
                            phase_next = hold_ticks;
                        end else begin
                            state_next = SQ_IDLE;
                            step_next  = 2'd0;
                            done       = 1'b1;
                        end
                    end
                    SQ_WRITE: begin
                        if (step_reg == 2'd0) begin
                            step_next  = 2'd1;
                            scl_next   = 1'b1;
                            phase_next = hold_ticks;
                        end else if (step_reg == 2'd1) begin
                            step_next  = 2'd2;
                            scl_next   = 1'b0;
                            phase_next = hold_ticks;
                        end else begin
                            bit_next = bit_inc;
                            if (bit_inc >= 4'd8) begin
                                state_next = SQ_IDLE;
                                step_next  = 2'd0;
                                done       = 1'b1;
                            end else begin
                                scl_next   = 1'b0;
                                sda_next   = shift_reg[7];
                                shift_next = {shift_reg[6:0], 1'b0};
                                step_next  = 2'd0;
                                phase_next = hold_ticks;
                            end
                        end
                    end
                    SQ_READ: begin
                        if (step_reg == 2'd0) begin
                            step_next  = 2'd1;
                            scl_next   = 1'b1;
                            phase_next = hold_ticks;
                        end else begin
                            bit_next = bit_inc;
                            scl_next = 1'b0;
                            if (bit_inc >= 4'd8) begin
                                shift_next = shift_in;
                                rx_next    = shift_in;
                                state_next = SQ_IDLE;
                                step_next  = 2'd0;
                                done       = 1'b1;
                            end else begin
                                shift_next = {shift_in[6:0], 1'b0};
                                step_next  = 2'd0;
                                phase_next = hold_ticks;
                            end
                        end
                    end
                    SQ_WAITACK: begin
                        if (step_reg == 2'd0) begin
                            step_next  = 2'd1;
                            scl_next   = 1'b1;
                            phase_next = hold_ticks;
                        end else begin
                            step_next  = 2'd2;
                            phase_next = 16'd0;
                        end
                    end
                    SQ_ACKNACK: begin
                        if (step_reg == 2'd0) begin
                            step_next  = 2'd1;
                            scl_next   = 1'b1;
                            phase_next = hold_ticks;
                        end else begin
                            scl_next   = 1'b0;
                            state_next = SQ_IDLE;
                            step_next  = 2'd0;
                            done       = 1'b1;
                        end
                    end
                    default: begin
                        state_next = state_reg;
                    end
                endcase
            end
        end
    end

    always_comb begin
        res.scl_drive  = scl_next;
        res.sda_drive  = sda_next;
        res.busy_res   = (state_next != SQ_IDLE);
        res.done_res   = done;
        res.rx_byte    = rx_next;
        res.ack_failed = fail_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= SQ_IDLE;
            step_reg        <= 2'd0;
            phase_reg       <= 16'd0;
            bit_reg         <= 4'd0;
            shift_reg       <= 8'd0;
            poll_reg        <= 8'd0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            fail_reg        <= 1'b0;
            rx_reg          <= 8'd0;
            m_valid_reg     <= 1'b0;
            phase_ticks_reg <= PHASE_TICKS_RESET;
            poll_limit_reg  <= ACK_POLL_LIMIT_RESET;
        end else begin
            if (q_pop) begin
                state_reg   <= state_next;
                step_reg    <= step_next;
                phase_reg   <= phase_next;
                bit_reg     <= bit_next;
                shift_reg   <= shift_next;
                poll_reg    <= poll_next;
                scl_reg     <= scl_next;
                sda_reg     <= sda_next;
                fail_reg    <= fail_next;
                rx_reg      <= rx_next;
                m_valid_reg <= 1'b1;
                m_res_reg   <= res;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            // out-of-range indexes fall through untouched
            if (cfg_valid) begin
                if (cfg_index == CFG_PHASE_TICKS) begin
                    phase_ticks_reg <= cfg_data;
                end else if (cfg_index == CFG_ACK_POLL_LIMIT) begin
                    poll_limit_reg <= cfg_data[7:0];
                end
            end
        end
    end

endmodule

/* rtl/i2c_master_bit_engine.sv */
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Open-drain I2C master bit engine stepped once per input transfer.
//
// Each transfer on the s_axis channel is one bus tick: it carries the sampled
// SDA level and, optionally, a command (start, stop, write, wait-ack, read,
// send ACK, send NACK). Each tick gives exactly one m_axis transfer with the
// SCL/SDA drive levels, busy, done, the last read byte and the ack-fail flag.
// Commands offered while a sequence runs are dropped.
// The cfg channel writes phase_ticks (index 0) and ack_poll_limit (index 1);
// cfg_ready is always high; the user must make writes only while the engine
// idles, and the block itself does not enforce this. Throughput: one tick per
// cycle while no result waits on a stalled m_axis. Each input tick is written
// into the queue, then stepped by the sequencer into the output register.
// The sequencer advances one tick per cycle while no result is stalled; the queue between front and
// sequencer holds QUEUE_DEPTH ticks.
// Reset (aresetn low, synchronous) releases both lines, idles the sequencer,
// empties the queue and restores 30 ticks per phase and 200 polls.
// When a result waits with m_axis_tready low, the result holds, the sequencer
// stops, and s_axis_tready drops once the queue fills.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] tx_byte, [8] sda_sample, [15:9] zero
    input  logic [i2cme_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // [0] cmd_valid, [3:1] mode
    input  logic [i2cme_pkg::IN_TUSER_W-1:0] s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] scl_drive, [1] sda_drive, [2] busy_res, [3] done_res,
    // [11:4] rx_byte, [12] ack_failed, [15:13] zero
    output logic [i2cme_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [i2cme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [i2cme_pkg::CFG_DATA_W-1:0] cfg_data
);
    import i2cme_pkg::*;

    cmd_t front_cmd;
    cmd_t q_data;
    logic q_full;
    logic q_valid;
    logic q_pop;

    assign s_axis_tready = !q_full;
    assign cfg_ready     = 1'b1;

    i2cme_front u_front (
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .cmd          (front_cmd)
    );

    i2cme_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_axis_tvalid && s_axis_tready),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    i2cme_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* rtl/i2cme_checker.sv */
// ----------------------------------------------------------------------------
// i2cme_checker
// Port-level checks for the I2C master bit engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cme_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    // a finishing tick is never busy
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
        else $error("done and busy together");

    // only a stop ends with SCL released, and it leaves SDA released too
    a_done_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[3] && m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("command finished with SCL high and SDA low");

    // padding bits above the result fields stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[15:13] == 3'd0)
        else $error("result padding not zero");

endmodule

bind i2c_master_bit_engine i2cme_checker u_i2cme_checker (.*);

/* tb/sv/i2c_master_bit_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_tb
// Self-checking bench for the I2C master bit engine. Every input transfer is
// one bus tick; a local bit-accurate copy of the sequencer predicts the line
// levels, busy/done, read byte and ack-fail flag for each tick, and every
// output transfer is compared against the oldest prediction. Stimulus runs
// directed corner commands, then well-formed bus transactions with random
// content mixed with junk ticks, under several phase/poll settings and
// random stalls on both channels.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;
    import i2cme_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int MAX_REPORTS = 40;
    localparam int RANDOM_ITEMS = 600;
    // indexes past the defined registers; the engine must ignore them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    i2c_master_bit_engine DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    cmd_t ticks_to_send[$];
    res_t tick_results_q[$];
    int   mismatches = 0;
    int   reports = 0;
    bit   steady = 1'b0;
    int   tx_gap = 0;
    int   rx_stall = 0;
    int   quiet = 0;
    int   accepted = 0;

    // shadow registers and sequencer state
    logic [15:0] set_ticks = PHASE_TICKS_RESET;
    logic [7:0]  set_poll_limit = ACK_POLL_LIMIT_RESET;
    op_t         eng_op = OP_NOP;
    int          eng_step = 0;
    int          eng_wait = 0;
    logic [3:0]  eng_bit = '0;
    logic [7:0]  eng_shift = '0;
    logic [7:0]  eng_polls = '0;
    logic        eng_scl = 1'b1;
    logic        eng_sda = 1'b1;
    logic        eng_fail = 1'b0;
    logic [7:0]  eng_rx = '0;
    logic        eng_done = 1'b0;

    function automatic int phase_len();
        return (set_ticks == 16'd0) ? 1 : int'(set_ticks);
    endfunction

    function automatic void end_command();
        eng_op = OP_NOP;
        eng_step = 0;
        eng_wait = 0;
        eng_done = 1'b1;
    endfunction

    function automatic void enter_stop();
        eng_op = OP_STOP;
        eng_step = 0;
        eng_scl = 1'b0;
        eng_sda = 1'b0;
        eng_wait = phase_len();
    endfunction

    function automatic void shift_out_bit();
        eng_scl = 1'b0;
        eng_sda = eng_shift[7];
        eng_shift = eng_shift << 1;
        eng_step = 0;
        eng_wait = phase_len();
    endfunction

    // Advance the shadow sequencer by one tick and return the line state.
    function automatic res_t bus_tick(cmd_t t);
        res_t r;
        eng_done = 1'b0;
        if (eng_op == OP_NOP) begin
            if (t.go && t.op != OP_NOP) begin
                eng_op = t.op;
                eng_step = 0;
                case (t.op)
                    OP_START: begin
                        eng_sda = 1'b1;
                        eng_scl = 1'b1;
                        eng_wait = phase_len();
                    end
                    OP_STOP: enter_stop();
                    OP_WRITE: begin
                        eng_shift = t.tx_byte;
                        eng_bit = '0;
                        shift_out_bit();
                    end
                    OP_WAITACK: begin
                        eng_fail = 1'b0;
                        eng_polls = '0;
                        eng_sda = 1'b1;
                        eng_wait = phase_len();
                    end
                    OP_READ: begin
                        eng_sda = 1'b1;
                        eng_shift = '0;
                        eng_bit = '0;
                        eng_scl = 1'b0;
                        eng_wait = phase_len();
                    end
                    default: begin
                        eng_scl = 1'b0;
                        eng_sda = (t.op == OP_NACK);
                        eng_wait = phase_len();
                    end
                endcase
            end
        end else if (eng_op == OP_WAITACK && eng_step == 2) begin
            if (!t.sda_sample) begin
                eng_scl = 1'b0;
                end_command();
            end else if (eng_polls >= set_poll_limit) begin
                eng_fail = 1'b1;
                enter_stop();
            end else begin
                eng_polls = eng_polls + 8'd1;
            end
        end else begin
            if (eng_wait > 0) eng_wait--;
            if (eng_wait == 0) begin
                // every sequence but start raises SCL when its first hold expires
                if (eng_op != OP_START && eng_step == 0) begin
                    eng_step = 1;
                    eng_scl = 1'b1;
                    eng_wait = phase_len();
                end else begin
                    case (eng_op)
                        OP_START: begin
                            if (eng_step == 0) begin
                                eng_step = 1;
                                eng_sda = 1'b0;
                                eng_wait = phase_len();
                            end else begin
                                eng_scl = 1'b0;
                                end_command();
                            end
                        end
                        OP_STOP: begin
                            if (eng_step == 1) begin
                                eng_step = 2;
                                eng_sda = 1'b1;
                                eng_wait = phase_len();
                            end else begin
                                end_command();
                            end
                        end
                        OP_WRITE: begin
                            if (eng_step == 1) begin
                                eng_step = 2;
                                eng_scl = 1'b0;
                                eng_wait = phase_len();
                            end else begin
                                eng_bit = eng_bit + 4'd1;
                                if (eng_bit >= 4'd8) end_command();
                                else shift_out_bit();
                            end
                        end
                        OP_READ: begin
                            eng_shift[0] = eng_shift[0] | t.sda_sample;
                            eng_bit = eng_bit + 4'd1;
                            eng_scl = 1'b0;
                            if (eng_bit >= 4'd8) begin
                                eng_rx = eng_shift;
                                end_command();
                            end else begin
                                eng_shift = eng_shift << 1;
                                eng_step = 0;
                                eng_wait = phase_len();
                            end
                        end
                        OP_WAITACK: begin
                            eng_step = 2;
                            eng_wait = 0;
                        end
                        default: begin
                            eng_scl = 1'b0;
                            end_command();
                        end
                    endcase
                end
            end
        end
        r.scl_drive  = eng_scl;
        r.sda_drive  = eng_sda;
        r.busy_res   = (eng_op != OP_NOP);
        r.done_res   = eng_done;
        r.rx_byte    = eng_rx;
        r.ack_failed = eng_fail;
        return r;
    endfunction

    function automatic int pick_pause();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Input driver: one tick per transfer, predicted as it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                tick_results_q.push_back(bus_tick(ticks_to_send.pop_front()));
                accepted++;
            end
            // hold the offered tick until it is taken
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (ticks_to_send.size() != 0) begin
                    s_axis_tdata  <= {7'd0, ticks_to_send[0].sda_sample,
                                      ticks_to_send[0].tx_byte};
                    s_axis_tuser  <= {ticks_to_send[0].op, ticks_to_send[0].go};
                    s_axis_tvalid <= 1'b1;
                    tx_gap = pick_pause();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            if (reports < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, want, got);
            reports++;
        end
    endtask

    res_t want_res;
    res_t got_res;

    // Output monitor with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_res = res_t'(m_axis_tdata[RES_W-1:0]);
                if (tick_results_q.size() == 0) begin
                    mismatches++;
                    if (reports < MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual %h",
                                 $time, m_axis_tdata);
                    reports++;
                end else begin
                    want_res = tick_results_q.pop_front();
                    check_field("scl_drive", 8'(want_res.scl_drive),
                                8'(got_res.scl_drive));
                    check_field("sda_drive", 8'(want_res.sda_drive),
                                8'(got_res.sda_drive));
                    check_field("busy_res", 8'(want_res.busy_res),
                                8'(got_res.busy_res));
                    check_field("done_res", 8'(want_res.done_res),
                                8'(got_res.done_res));
                    check_field("rx_byte", want_res.rx_byte, got_res.rx_byte);
                    check_field("ack_failed", 8'(want_res.ack_failed),
                                8'(got_res.ack_failed));
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) rx_stall = pick_pause();
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("i2c_master_bit_engine_tb: done, errors");
                $finish;
            end
        end
    end

    function automatic cmd_t junk_tick();
        cmd_t t;
        t.go = ($urandom_range(0, 9) < 3);
        t.op = op_t'($urandom_range(0, 7));
        t.tx_byte = 8'($urandom);
        t.sda_sample = 1'($urandom);
        return t;
    endfunction

    task automatic wait_sent();
        while (ticks_to_send.size() != 0) @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        while (ticks_to_send.size() != 0 || tick_results_q.size() != 0)
            @(negedge aclk);
    endtask

    // Offer one command tick on an idle engine, then feed ticks until it idles.
    // high_polls is the number of SDA-high polls before SDA goes low.
    task automatic issue(logic go, op_t op, logic [7:0] tx, int high_polls);
        cmd_t t;
        int   polls_sent;
        int   n;
        wait_sent();
        t.go = go;
        t.op = op;
        t.tx_byte = tx;
        t.sda_sample = 1'($urandom);
        ticks_to_send.push_back(t);
        polls_sent = 0;
        forever begin
            wait_sent();
            if (eng_op == OP_NOP) break;
            if (eng_op == OP_WAITACK && eng_step == 2) begin
                t = junk_tick();
                t.sda_sample = (polls_sent < high_polls);
                polls_sent++;
                ticks_to_send.push_back(t);
            end else begin
                // ticks short of the hold expiring cannot change the sequence
                n = (eng_wait > 1) ? eng_wait - 1 : 1;
                repeat (n) ticks_to_send.push_back(junk_tick());
            end
        end
    endtask

    function automatic int ack_polls();
        int cap;
        if ($urandom_range(0, 3) == 0) return int'(set_poll_limit) + 1;
        cap = (set_poll_limit < 8'd8) ? int'(set_poll_limit) : 8;
        return $urandom_range(0, cap);
    endfunction

    task automatic bus_transaction(output int cmds);
        int nbytes;
        issue(1'b1, OP_START, 8'($urandom), 0);
        issue(1'b1, OP_WRITE, 8'($urandom), 0);
        issue(1'b1, OP_WAITACK, 8'($urandom), ack_polls());
        cmds = 4;
        nbytes = $urandom_range(1, 3);
        repeat (nbytes) begin
            if ($urandom_range(0, 1) == 0) begin
                issue(1'b1, OP_WRITE, 8'($urandom), 0);
                issue(1'b1, OP_WAITACK, 8'($urandom), ack_polls());
            end else begin
                issue(1'b1, OP_READ, 8'($urandom), 0);
                issue(1'b1, ($urandom_range(0, 1) == 0) ? OP_ACK : OP_NACK,
                      8'($urandom), 0);
            end
            cmds += 2;
        end
        issue(1'b1, OP_STOP, 8'($urandom), 0);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_results_drained();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_PHASE_TICKS) set_ticks = val;
        else if (idx == CFG_ACK_POLL_LIMIT) set_poll_limit = val[7:0];
    endtask

    initial begin : stimulus
        int k;
        int cmds;
        int pick;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: one start condition at the default phase length
        issue(1'b1, OP_START, 8'h00, 0);

        // zero phase length and zero poll limit
        set_reg(CFG_PHASE_TICKS, 16'd0);
        set_reg(CFG_ACK_POLL_LIMIT, 16'd0);
        issue(1'b1, OP_START, 8'h00, 0);
        issue(1'b1, OP_WRITE, 8'h80, 0);
        issue(1'b1, OP_WAITACK, 8'h00, 1);
        issue(1'b1, OP_START, 8'hFF, 0);
        issue(1'b1, OP_WRITE, 8'h00, 0);
        issue(1'b1, OP_WAITACK, 8'hFF, 0);
        issue(1'b1, OP_READ, 8'hFF, 0);
        issue(1'b1, OP_ACK, 8'h00, 0);
        issue(1'b1, OP_NOP, 8'hFF, 0);
        issue(1'b0, OP_START, 8'h5A, 0);
        issue(1'b1, OP_STOP, 8'h00, 0);

        // widest poll window: time out after the last allowed poll
        set_reg(CFG_PHASE_TICKS, 16'd1);
        set_reg(CFG_ACK_POLL_LIMIT, 16'd255);
        issue(1'b1, OP_WAITACK, 8'h00, 256);
        set_reg(CFG_SPARE_2, 16'hFFFF);
        set_reg(CFG_SPARE_3, 16'h0000);
        issue(1'b1, OP_START, 8'h00, 0);

        k = 0;
        while (accepted < RANDOM_ITEMS) begin
            if (k % 3 == 0) begin
                set_reg(CFG_PHASE_TICKS, 16'($urandom_range(0, 2)));
                set_reg(CFG_ACK_POLL_LIMIT, 16'($urandom_range(0, 6)));
                steady = (k % 6 == 3);
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                bus_transaction(cmds);
            end else if (pick < 8) begin
                issue(1'b1, op_t'($urandom_range(0, 7)), 8'($urandom), ack_polls());
            end else begin
                // unaligned junk, then let the engine settle
                repeat ($urandom_range(10, 30)) begin
                    ticks_to_send.push_back(junk_tick());
                    ticks_to_send[$].go = 1'($urandom);
                end
                issue(1'b0, OP_NOP, 8'h00, 0);
            end
            k++;
        end

        wait_results_drained();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("i2c_master_bit_engine_tb: done, clean");
        end else begin
            $display("i2c_master_bit_engine_tb: done, errors");
        end
        $finish;
    end

endmodule
